// File: sv/lpht_pkg.sv
// Package for the linear-probe hash table: table geometry, status codes and
// the request word passed from the front end to the probe engine. No dependencies.
package lpht_pkg;

  // Slot count; the home slot is the key modulo this count, so keep this a power of two
  localparam int unsigned TABLE_SIZE = 16;
  localparam int unsigned IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_SIZE + 1);

  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STS_W = 3;
  localparam int unsigned OCC_W = 5;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STS_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [STS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STS_W-1:0] ST_HIT     = 3'd3;
  localparam logic [STS_W-1:0] ST_MISS    = 3'd4;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] home;
  } lpht_req_t;

endpackage

// File: sv/linear_probe_hash_table.sv
// Top level of the linear-probe hash table: front end, request queue and
// probe engine. Depends on lpht_pkg, lpht_front, lpht_queue, lpht_back.
//
//   word      direction  handshake             payload
//   request   in         in_valid / in_ready   in_operation, in_key, in_value
//   result    out        out_valid / out_ready out_status, out_found_value,
//                                              out_occupied, out_table_empty
//
// A request probes p slots (1 to TABLE_SIZE) between acceptance and result,
// one slot a cycle through the single slot-store read port. Requests are
// handled one at a time by the probe engine.
// Reset clears every slot valid bit and the entry count.
// The queue keeps taking requests, until it is full, while the engine works or a result waits;
// a stalled result holds the engine, never the stored table.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_operation,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STS_W-1:0]        out_status,
  output logic signed [VAL_W-1:0] out_found_value,
  output logic [OCC_W-1:0]        out_occupied,
  output logic                    out_table_empty
);

  logic      q_full, q_push, q_pop, q_not_empty;
  lpht_req_t q_req, q_head;

  lpht_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_value     (in_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_req        (q_req)
  );

  lpht_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (q_req),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lpht_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_occupied    (out_occupied),
    .out_table_empty (out_table_empty)
  );

endmodule

// File: sv/lpht_front.sv
// Front end: takes request words from the input channel, works out the home slot
// and pushes the request into the queue. Depends on lpht_pkg.
module lpht_front
  import lpht_pkg::*;
(
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_operation,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    q_full,
  output logic                    q_push,
  output lpht_req_t               q_req
);

  logic [KEY_W-1:0] home_full;

  assign in_ready  = ~q_full;
  assign q_push    = in_valid & ~q_full;
  assign home_full = in_key % KEY_W'(TABLE_SIZE);

  always_comb begin
    q_req.op    = in_operation;
    q_req.key   = in_key;
    q_req.value = in_value;
    q_req.home  = home_full[IDX_W-1:0];
  end

endmodule

// File: sv/lpht_queue.sv
// Two-word queue between the front end and the probe engine.
// Depends on lpht_pkg.
module lpht_queue
  import lpht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lpht_req_t push_req,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output lpht_req_t head
);

  lpht_req_t          slots_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slots_r[rd_ptr_r];
  assign do_pop    = pop & not_empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// File: sv/lpht_back.sv
// Probe engine: walks the slots from the home slot, one memory read a cycle,
// applies the insert or lookup and holds the result word. Depends on lpht_pkg.
module lpht_back
  import lpht_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  lpht_req_t               q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STS_W-1:0]        out_status,
  output logic signed [VAL_W-1:0] out_found_value,
  output logic [OCC_W-1:0]        out_occupied,
  output logic                    out_table_empty
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;

  logic [KEY_W-1:0] key_mem [TABLE_SIZE];
  logic [VAL_W-1:0] val_mem [TABLE_SIZE];

  logic [1:0]       state_r, state_nxt;
  lpht_req_t        req_r, req_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0] chk_cnt_r, chk_cnt_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r;
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;

  logic [IDX_W-1:0] where_r, where_nxt;
  logic             match_r, match_nxt;
  logic             stopped_r, stopped_nxt;
  logic [VAL_W-1:0] found_r, found_nxt;

  logic [TABLE_SIZE-1:0] slot_valid_r, slot_valid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [STS_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_found_r, out_found_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic             mem_we, mem_new;
  logic [STS_W-1:0] sts;
  logic [CNT_W-1:0] cnt_after;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    rd_idx_nxt     = rd_idx_r;
    iss_cnt_nxt    = iss_cnt_r;
    chk_cnt_nxt    = chk_cnt_r;
    chk_v_nxt      = 1'b0;
    where_nxt      = where_r;
    match_nxt      = match_r;
    stopped_nxt    = stopped_r;
    found_nxt      = found_r;
    slot_valid_nxt = slot_valid_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_new        = 1'b0;
    sts            = ST_MISS;
    cnt_after      = count_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          req_nxt     = q_head;
          rd_idx_nxt  = q_head.home;
          iss_cnt_nxt = '0;
          chk_cnt_nxt = '0;
          state_nxt   = S_PROBE;
        end
      end
      S_PROBE: begin
        // issue the next read while the previous one is checked
        if (iss_cnt_r != CNT_W'(TABLE_SIZE)) begin
          chk_v_nxt   = 1'b1;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          rd_idx_nxt  = (rd_idx_r == IDX_W'(TABLE_SIZE - 1)) ? '0 : rd_idx_r + 1'b1;
        end
        if (chk_v_r) begin
          if (!slot_valid_r[chk_idx_r]) begin
            where_nxt   = chk_idx_r;
            match_nxt   = 1'b0;
            stopped_nxt = 1'b1;
            state_nxt   = S_FIN;
          end else if (rd_key_r == req_r.key) begin
            where_nxt   = chk_idx_r;
            match_nxt   = 1'b1;
            stopped_nxt = 1'b1;
            found_nxt   = rd_val_r;
            state_nxt   = S_FIN;
          end else if (chk_cnt_r == CNT_W'(TABLE_SIZE - 1)) begin
            match_nxt   = 1'b0;
            stopped_nxt = 1'b0;
            state_nxt   = S_FIN;
          end else begin
            chk_cnt_nxt = chk_cnt_r + 1'b1;
          end
          // drop the read in flight once the walk stops
          if (state_nxt == S_FIN) begin
            chk_v_nxt = 1'b0;
          end
        end
      end
      S_FIN: begin
        if (req_r.op == OP_INSERT) begin
          if (!stopped_r) begin
            sts = ST_FULL;
          end else if (match_r) begin
            sts    = ST_UPDATED;
            mem_we = 1'b1;
          end else begin
            sts       = ST_NEW;
            mem_we    = 1'b1;
            mem_new   = 1'b1;
            cnt_after = count_r + 1'b1;
          end
        end else begin
          sts = (stopped_r && match_r) ? ST_HIT : ST_MISS;
        end
        // hold until the result register is free; commit exactly once
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sts;
          out_found_nxt  = (sts == ST_HIT) ? found_r : '0;
          out_count_nxt  = cnt_after;
          count_nxt      = cnt_after;
          if (mem_new) begin
            slot_valid_nxt[where_r] = 1'b1;
          end
          state_nxt = S_IDLE;
        end else begin
          mem_we  = 1'b0;
          mem_new = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chk_v_r      <= 1'b0;
      slot_valid_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chk_v_r      <= chk_v_nxt;
      slot_valid_r <= slot_valid_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    rd_idx_r     <= rd_idx_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    chk_cnt_r    <= chk_cnt_nxt;
    where_r      <= where_nxt;
    match_r      <= match_nxt;
    stopped_r    <= stopped_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (mem_new) begin
        key_mem[where_r] <= req_r.key;
      end
      val_mem[where_r] <= req_r.value;
    end
    rd_key_r  <= key_mem[rd_idx_r];
    rd_val_r  <= val_mem[rd_idx_r];
    chk_idx_r <= rd_idx_r;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_occupied    = OCC_W'(out_count_r);
  assign out_table_empty = (out_count_r == '0);

endmodule

// File: sv/lpht_checker.sv
// Port-level checks for the linear-probe hash table, bound to the top level.
// Depends on lpht_pkg and linear_probe_hash_table.
module lpht_checker
  import lpht_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STS_W-1:0]        out_status,
  input logic signed [VAL_W-1:0] out_found_value,
  input logic [OCC_W-1:0]        out_occupied,
  input logic                    out_table_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_occupied))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_NEW || out_status == ST_UPDATED ||
                   out_status == ST_FULL || out_status == ST_HIT || out_status == ST_MISS))
    else $error("undefined status code");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_HIT |-> out_found_value == '0)
    else $error("found value not zero outside a hit");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_NEW |-> (out_table_empty == (out_occupied == '0)))
    else $error("empty flag disagrees with occupancy");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_found_value (out_found_value),
  .out_occupied    (out_occupied),
  .out_table_empty (out_table_empty)
);
